[sv/ptgi_pkg.sv]
// ----------------------------------------------------------------------------
// ptgi_pkg
// Shared widths, register codes, reset values, types and the count clamp of
// the periodic tower grid index block.
// ----------------------------------------------------------------------------
package ptgi_pkg;

   localparam int COORD_W     = 16;
   localparam int MAX_W       = 15;
   localparam int COUNT_W     = 7;
   localparam int PBIN_W      = 6;
   localparam int TOWER_W     = 13;
   localparam int DIVISOR_W   = MAX_W + 1;
   localparam int NUM_W       = 23;
   localparam int QUO_W       = 7;
   localparam int DIV_STAGES  = QUO_W;
   localparam int DIV_LAST    = DIV_STAGES - 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 32;
   localparam int REG_IDX_W   = 3;

   localparam logic [COUNT_W-1:0] MAX_ETA_BINS = 7'd64;
   localparam logic [COUNT_W-1:0] MAX_PHI_BINS = 7'd64;

   localparam logic [NUM_W-1:0] PHI_HALF_TURN = 23'd32768;

   localparam logic [MAX_W-1:0]   RESET_MAX_ETA    = 15'd20480;
   localparam logic [COUNT_W-1:0] RESET_ETA_TOWERS = 7'd50;
   localparam logic [COUNT_W-1:0] RESET_PHI_TOWERS = 7'd64;

   localparam logic [REG_IDX_W-1:0] REG_MAX_ETA    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ETA_TOWERS = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PHI_TOWERS = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SHIFT_ETA  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SHIFT_PHI  = 3'd4;

   typedef struct packed {
      logic [MAX_W-1:0]   max_eta;
      logic [COUNT_W-1:0] eta_count;
      logic [COUNT_W-1:0] phi_count;
      logic               shift_eta;
      logic               shift_phi;
   } grid_cfg_type;

   typedef struct packed {
      logic               out_of_range;
      logic [NUM_W-1:0]   numer;
      logic [COUNT_W-1:0] phi_raw;
   } work_type;

   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] value,
                                                      input logic [COUNT_W-1:0] limit);
      logic [COUNT_W-1:0] result;
      result = value;
      if (value == '0) begin
         result = {{(COUNT_W-1){1'b0}}, 1'b1};
      end else if (value > limit) begin
         result = limit;
      end
      return result;
   endfunction

endpackage

[sv/ptgi_if.sv]
// ----------------------------------------------------------------------------
// ptgi_if
// Request and response channels of the tower grid index block.
// ----------------------------------------------------------------------------
interface ptgi_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ptgi_pkg::COORD_W-1:0]  eta_coord;
   logic        [ptgi_pkg::COORD_W-1:0]  phi_angle;

   modport source (output valid, output eta_coord, output phi_angle, input ready);
   modport sink   (input valid, input eta_coord, input phi_angle, output ready);
endinterface

interface ptgi_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ptgi_pkg::TOWER_W-1:0]   tower_index;
   logic [ptgi_pkg::COUNT_W-1:0]   eta_bin;
   logic [ptgi_pkg::PBIN_W-1:0]    phi_bin;
   logic                           out_of_range;

   modport source (output valid, output tower_index, output eta_bin, output phi_bin,
                   output out_of_range, input ready);
   modport sink   (input valid, input tower_index, input eta_bin, input phi_bin,
                   input out_of_range, output ready);
endinterface

[sv/ptgi_front.sv]
// ----------------------------------------------------------------------------
// ptgi_front
// Accepts coordinates, flags out-of-range eta and forms the eta numerator
// and the raw phi bin for the back end.
// ----------------------------------------------------------------------------
module ptgi_front (
   ptgi_req_if.sink                req_chan,
   input  ptgi_pkg::grid_cfg_type  cfg,
   input  logic                    queue_full,
   output logic                    push,
   output ptgi_pkg::work_type      entry
);

   logic [ptgi_pkg::COORD_W-1:0] eta_u;
   logic [ptgi_pkg::COORD_W-1:0] mag;
   logic [ptgi_pkg::COORD_W-1:0] offset_eta;
   logic [ptgi_pkg::NUM_W-1:0]   eta_prod;
   logic [ptgi_pkg::NUM_W-1:0]   phi_prod;
   logic [ptgi_pkg::NUM_W-1:0]   phi_numer;

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   assign eta_u      = $unsigned(req_chan.eta_coord);
   assign mag        = eta_u[ptgi_pkg::COORD_W-1] ? (~eta_u + 1'b1) : eta_u;
   assign offset_eta = eta_u + {1'b0, cfg.max_eta};

   assign eta_prod = {{(ptgi_pkg::NUM_W-ptgi_pkg::COORD_W){1'b0}}, offset_eta}
                   * {{(ptgi_pkg::NUM_W-ptgi_pkg::COUNT_W){1'b0}}, cfg.eta_count};
   assign phi_prod = {{(ptgi_pkg::NUM_W-ptgi_pkg::COORD_W){1'b0}}, req_chan.phi_angle}
                   * {{(ptgi_pkg::NUM_W-ptgi_pkg::COUNT_W){1'b0}}, cfg.phi_count};
   assign phi_numer = phi_prod + (cfg.shift_phi ? ptgi_pkg::PHI_HALF_TURN
                                                : {ptgi_pkg::NUM_W{1'b0}});

   always_comb begin
      entry.out_of_range = (mag >= {1'b0, cfg.max_eta});
      entry.numer        = eta_prod
                         + (cfg.shift_eta
                            ? {{(ptgi_pkg::NUM_W-ptgi_pkg::MAX_W){1'b0}}, cfg.max_eta}
                            : {ptgi_pkg::NUM_W{1'b0}});
      entry.phi_raw      = phi_numer[ptgi_pkg::NUM_W-1 -: ptgi_pkg::COUNT_W];
   end

endmodule

[sv/ptgi_queue.sv]
// ----------------------------------------------------------------------------
// ptgi_queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module ptgi_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ptgi_pkg::work_type  push_entry,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output ptgi_pkg::work_type  head
);

   ptgi_pkg::work_type            entry_ff [ptgi_pkg::QUEUE_DEPTH];
   logic [ptgi_pkg::QPTR_W-1:0]   wr_ptr_ff;
   logic [ptgi_pkg::QPTR_W-1:0]   wr_ptr_in;
   logic [ptgi_pkg::QPTR_W-1:0]   rd_ptr_ff;
   logic [ptgi_pkg::QPTR_W-1:0]   rd_ptr_in;
   logic [ptgi_pkg::QPTR_W:0]     count_ff;
   logic [ptgi_pkg::QPTR_W:0]     count_in;

   assign full      = (count_ff == (ptgi_pkg::QPTR_W+1)'(ptgi_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (ptgi_pkg::QPTR_W+1)'(ptgi_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");
`endif

endmodule

[sv/ptgi_back.sv]
// ----------------------------------------------------------------------------
// ptgi_back
// Pipelined restoring divide of the eta numerator, bin wrap and global
// index build, with a registered response stage.
// ----------------------------------------------------------------------------
module ptgi_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ptgi_pkg::grid_cfg_type  cfg,
   input  logic                    head_valid,
   input  ptgi_pkg::work_type      head,
   output logic                    pop,
   ptgi_rsp_if.source              rsp_chan
);

   logic                           advance;
   logic [ptgi_pkg::DIVISOR_W-1:0] divisor;

   logic                           dv_valid_ff [ptgi_pkg::DIV_STAGES];
   logic                           dv_valid_in [ptgi_pkg::DIV_STAGES];
   logic                           dv_oor_ff   [ptgi_pkg::DIV_STAGES];
   logic                           dv_oor_in   [ptgi_pkg::DIV_STAGES];
   logic [ptgi_pkg::NUM_W-1:0]     dv_rem_ff   [ptgi_pkg::DIV_STAGES];
   logic [ptgi_pkg::NUM_W-1:0]     dv_rem_in   [ptgi_pkg::DIV_STAGES];
   logic [ptgi_pkg::QUO_W-1:0]     dv_quo_ff   [ptgi_pkg::DIV_STAGES];
   logic [ptgi_pkg::QUO_W-1:0]     dv_quo_in   [ptgi_pkg::DIV_STAGES];
   logic [ptgi_pkg::COUNT_W-1:0]   dv_phi_ff   [ptgi_pkg::DIV_STAGES];
   logic [ptgi_pkg::COUNT_W-1:0]   dv_phi_in   [ptgi_pkg::DIV_STAGES];

   logic                           wr_valid_ff;
   logic                           wr_oor_ff;
   logic                           wr_oor_in;
   logic [ptgi_pkg::COUNT_W-1:0]   wr_ebin_ff;
   logic [ptgi_pkg::COUNT_W-1:0]   wr_ebin_in;
   logic [ptgi_pkg::PBIN_W-1:0]    wr_pbin_ff;
   logic [ptgi_pkg::PBIN_W-1:0]    wr_pbin_in;
   logic [ptgi_pkg::COUNT_W-1:0]   phi_wrapped;

   logic                           rsp_valid_ff;
   logic [ptgi_pkg::TOWER_W-1:0]   tower_ff;
   logic [ptgi_pkg::TOWER_W-1:0]   tower_in;
   logic [ptgi_pkg::COUNT_W-1:0]   eta_bin_ff;
   logic [ptgi_pkg::COUNT_W-1:0]   eta_bin_in;
   logic [ptgi_pkg::PBIN_W-1:0]    phi_bin_ff;
   logic [ptgi_pkg::PBIN_W-1:0]    phi_bin_in;
   logic                           oor_ff;

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign pop     = advance && head_valid;
   assign divisor = {cfg.max_eta, 1'b0};

   // one quotient bit per stage, most significant first
   always_comb begin
      logic [ptgi_pkg::NUM_W-1:0] src_rem;
      logic [ptgi_pkg::QUO_W-1:0] src_quo;
      logic [ptgi_pkg::NUM_W-1:0] trial;
      for (int s = 0; s < ptgi_pkg::DIV_STAGES; s++) begin
         if (s == 0) begin
            dv_valid_in[s] = pop;
            dv_oor_in[s]   = head.out_of_range;
            dv_phi_in[s]   = head.phi_raw;
            src_rem        = head.numer;
            src_quo        = '0;
         end else begin
            dv_valid_in[s] = dv_valid_ff[s-1];
            dv_oor_in[s]   = dv_oor_ff[s-1];
            dv_phi_in[s]   = dv_phi_ff[s-1];
            src_rem        = dv_rem_ff[s-1];
            src_quo        = dv_quo_ff[s-1];
         end
         trial = {{(ptgi_pkg::NUM_W-ptgi_pkg::DIVISOR_W){1'b0}}, divisor}
                 << (ptgi_pkg::DIV_LAST - s);
         if (src_rem >= trial) begin
            dv_rem_in[s] = src_rem - trial;
            dv_quo_in[s] = src_quo | (ptgi_pkg::QUO_W'(1) << (ptgi_pkg::DIV_LAST - s));
         end else begin
            dv_rem_in[s] = src_rem;
            dv_quo_in[s] = src_quo;
         end
      end
   end

   always_comb begin
      wr_oor_in   = dv_oor_ff[ptgi_pkg::DIV_LAST];
      wr_ebin_in  = (dv_quo_ff[ptgi_pkg::DIV_LAST] >= cfg.eta_count)
                    ? dv_quo_ff[ptgi_pkg::DIV_LAST] - cfg.eta_count
                    : dv_quo_ff[ptgi_pkg::DIV_LAST];
      phi_wrapped = (dv_phi_ff[ptgi_pkg::DIV_LAST] >= cfg.phi_count)
                    ? dv_phi_ff[ptgi_pkg::DIV_LAST] - cfg.phi_count
                    : dv_phi_ff[ptgi_pkg::DIV_LAST];
      wr_pbin_in  = phi_wrapped[ptgi_pkg::PBIN_W-1:0];
   end

   always_comb begin
      eta_bin_in = wr_oor_ff ? cfg.eta_count : wr_ebin_ff;
      phi_bin_in = wr_oor_ff ? '0 : wr_pbin_ff;
      tower_in   = {{(ptgi_pkg::TOWER_W-ptgi_pkg::COUNT_W){1'b0}}, eta_bin_in}
                 * {{(ptgi_pkg::TOWER_W-ptgi_pkg::COUNT_W){1'b0}}, cfg.phi_count}
                 + {{(ptgi_pkg::TOWER_W-ptgi_pkg::PBIN_W){1'b0}}, phi_bin_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < ptgi_pkg::DIV_STAGES; s++) begin
            dv_valid_ff[s] <= 1'b0;
         end
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         for (int s = 0; s < ptgi_pkg::DIV_STAGES; s++) begin
            dv_valid_ff[s] <= dv_valid_in[s];
         end
         wr_valid_ff  <= dv_valid_ff[ptgi_pkg::DIV_LAST];
         rsp_valid_ff <= wr_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < ptgi_pkg::DIV_STAGES; s++) begin
            dv_oor_ff[s] <= dv_oor_in[s];
            dv_rem_ff[s] <= dv_rem_in[s];
            dv_quo_ff[s] <= dv_quo_in[s];
            dv_phi_ff[s] <= dv_phi_in[s];
         end
         wr_oor_ff  <= wr_oor_in;
         wr_ebin_ff <= wr_ebin_in;
         wr_pbin_ff <= wr_pbin_in;
         tower_ff   <= tower_in;
         eta_bin_ff <= eta_bin_in;
         phi_bin_ff <= phi_bin_in;
         oor_ff     <= wr_oor_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.tower_index  = tower_ff;
   assign rsp_chan.eta_bin      = eta_bin_ff;
   assign rsp_chan.phi_bin      = phi_bin_ff;
   assign rsp_chan.out_of_range = oor_ff;

`ifndef NO_ASSERTIONS
   a_eta_bin_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !oor_ff) |-> (eta_bin_ff < cfg.eta_count))
      else $error("eta bin not below tower count");

   a_phi_bin_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !oor_ff) |-> ({1'b0, phi_bin_ff} < cfg.phi_count))
      else $error("phi bin not below tower count");

   a_oor_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && oor_ff) |-> (phi_bin_ff == '0 && eta_bin_ff == cfg.eta_count))
      else $error("out-of-range response fields wrong");
`endif

endmodule

[sv/periodic_tower_grid_index.sv]
// ----------------------------------------------------------------------------
// periodic_tower_grid_index
// Maps an (eta, phi) coordinate to its tower in a periodic eta/phi grid.
// ----------------------------------------------------------------------------
// Use:
//   req_chan carries one coordinate per transfer (eta_coord, phi_angle);
//   rsp_chan returns one result per transfer (tower_index, eta_bin,
//   phi_bin, out_of_range), in order of the requests.
//   The APB port sets the grid: max_eta at 0x0, eta_towers at 0x4,
//   phi_towers at 0x8, shift_eta at 0xC, shift_phi at 0x10. Write it only
//   while no request is in flight.
// Timing:
//   A result passes through the queue slot, the seven-stage eta divider, the
//   bin wrap stage and the final multiply-add stage. One request is taken
//   every cycle while the queue is not full.
// Reset:
//   Synchronous reset empties the queue and the pipeline and loads the
//   default grid (max_eta 20480, 50 by 64 towers, no shift).
// Stall:
//   While rsp_chan holds an untaken result the back end holds; a four-entry
//   queue keeps taking requests, and req_chan.ready drops once it is full.
// ----------------------------------------------------------------------------
module periodic_tower_grid_index (
   input  logic                          clock,
   input  logic                          reset,
   ptgi_req_if.sink                      req_chan,
   ptgi_rsp_if.source                    rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ptgi_pkg::ADDR_W-1:0]   paddr,
   input  logic [ptgi_pkg::DATA_W-1:0]   pwdata,
   output logic [ptgi_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   logic [ptgi_pkg::MAX_W-1:0]     max_eta_ff;
   logic [ptgi_pkg::MAX_W-1:0]     max_eta_in;
   logic [ptgi_pkg::COUNT_W-1:0]   eta_towers_ff;
   logic [ptgi_pkg::COUNT_W-1:0]   eta_towers_in;
   logic [ptgi_pkg::COUNT_W-1:0]   phi_towers_ff;
   logic [ptgi_pkg::COUNT_W-1:0]   phi_towers_in;
   logic                           shift_eta_ff;
   logic                           shift_eta_in;
   logic                           shift_phi_ff;
   logic                           shift_phi_in;
   logic                           csr_write;
   logic [ptgi_pkg::REG_IDX_W-1:0] reg_idx;

   ptgi_pkg::grid_cfg_type         cfg;
   ptgi_pkg::work_type             push_entry;
   ptgi_pkg::work_type             head;
   logic                           push;
   logic                           pop;
   logic                           queue_full;
   logic                           queue_not_empty;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_idx   = paddr[ptgi_pkg::ADDR_W-1:2];

   always_comb begin
      max_eta_in    = max_eta_ff;
      eta_towers_in = eta_towers_ff;
      phi_towers_in = phi_towers_ff;
      shift_eta_in  = shift_eta_ff;
      shift_phi_in  = shift_phi_ff;
      if (csr_write) begin
         case (reg_idx)
            ptgi_pkg::REG_MAX_ETA:    max_eta_in    = pwdata[ptgi_pkg::MAX_W-1:0];
            ptgi_pkg::REG_ETA_TOWERS: eta_towers_in = pwdata[ptgi_pkg::COUNT_W-1:0];
            ptgi_pkg::REG_PHI_TOWERS: phi_towers_in = pwdata[ptgi_pkg::COUNT_W-1:0];
            ptgi_pkg::REG_SHIFT_ETA:  shift_eta_in  = pwdata[0];
            ptgi_pkg::REG_SHIFT_PHI:  shift_phi_in  = pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_eta_ff    <= ptgi_pkg::RESET_MAX_ETA;
         eta_towers_ff <= ptgi_pkg::RESET_ETA_TOWERS;
         phi_towers_ff <= ptgi_pkg::RESET_PHI_TOWERS;
         shift_eta_ff  <= 1'b0;
         shift_phi_ff  <= 1'b0;
      end else begin
         max_eta_ff    <= max_eta_in;
         eta_towers_ff <= eta_towers_in;
         phi_towers_ff <= phi_towers_in;
         shift_eta_ff  <= shift_eta_in;
         shift_phi_ff  <= shift_phi_in;
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_idx)
         ptgi_pkg::REG_MAX_ETA:    prdata[ptgi_pkg::MAX_W-1:0]   = max_eta_ff;
         ptgi_pkg::REG_ETA_TOWERS: prdata[ptgi_pkg::COUNT_W-1:0] = eta_towers_ff;
         ptgi_pkg::REG_PHI_TOWERS: prdata[ptgi_pkg::COUNT_W-1:0] = phi_towers_ff;
         ptgi_pkg::REG_SHIFT_ETA:  prdata[0]                     = shift_eta_ff;
         ptgi_pkg::REG_SHIFT_PHI:  prdata[0]                     = shift_phi_ff;
         default: begin
         end
      endcase
   end

   always_comb begin
      cfg.max_eta   = max_eta_ff;
      cfg.eta_count = ptgi_pkg::clamp_count(eta_towers_ff, ptgi_pkg::MAX_ETA_BINS);
      cfg.phi_count = ptgi_pkg::clamp_count(phi_towers_ff, ptgi_pkg::MAX_PHI_BINS);
      cfg.shift_eta = shift_eta_ff;
      cfg.shift_phi = shift_phi_ff;
   end

   ptgi_front u_front (
      .req_chan   (req_chan),
      .cfg        (cfg),
      .queue_full (queue_full),
      .push       (push),
      .entry      (push_entry)
   );

   ptgi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   ptgi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (queue_not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

[test/tower_grid_checker.sv]
// ----------------------------------------------------------------------------
// tower_grid_checker
// Watches the coordinate and tower channels and the APB port of the tower
// grid index block. It keeps its own copy of the grid registers, works out
// the tower of every accepted coordinate, and compares each returned tower
// field by field, in order. Register reads are compared with the copy.
// ----------------------------------------------------------------------------
module tower_grid_checker
   import ptgi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   ptgi_req_if               req_chan,
   ptgi_rsp_if               rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   input  logic [DATA_W-1:0] prdata,
   input  logic              pready,
   output int                fail_count,
   output int                results_seen,
   output int                pending
);

   typedef struct packed {
      logic [TOWER_W-1:0] tower_index;
      logic [COUNT_W-1:0] eta_bin;
      logic [PBIN_W-1:0]  phi_bin;
      logic               out_of_range;
   } tower_hit_type;

   grid_cfg_type  grid;
   tower_hit_type expected_towers[$];

   function automatic tower_hit_type locate_tower(input logic signed [COORD_W-1:0] eta,
                                                  input logic [COORD_W-1:0] phi,
                                                  input grid_cfg_type g);
      int unsigned   ne, np, mag, m, u, num, ebin, pbin, pnum;
      int            e;
      tower_hit_type t;
      ne = (g.eta_count == '0) ? 1 : ((g.eta_count > MAX_ETA_BINS) ? MAX_ETA_BINS : g.eta_count);
      np = (g.phi_count == '0) ? 1 : ((g.phi_count > MAX_PHI_BINS) ? MAX_PHI_BINS : g.phi_count);
      e = eta;
      mag = (e < 0) ? -e : e;
      m = g.max_eta;
      if (mag >= m) begin
         t.out_of_range = 1'b1;
         t.eta_bin = ne[COUNT_W-1:0];
         t.phi_bin = '0;
         t.tower_index = TOWER_W'(ne * np);
      end else begin
         u = e + m;
         num = u * ne + (g.shift_eta ? m : 0);
         ebin = num / (2 * m);
         if (ebin >= ne) begin
            ebin = ebin - ne;
         end
         pnum = phi * np + (g.shift_phi ? 32768 : 0);
         pbin = pnum >> 16;
         if (pbin >= np) begin
            pbin = pbin - np;
         end
         t.out_of_range = 1'b0;
         t.eta_bin = ebin[COUNT_W-1:0];
         t.phi_bin = pbin[PBIN_W-1:0];
         t.tower_index = TOWER_W'(ebin * np + pbin);
      end
      return t;
   endfunction

   function automatic logic [DATA_W-1:0] grid_reg_value(input logic [REG_IDX_W-1:0] idx);
      logic [DATA_W-1:0] v;
      v = '0;
      case (idx)
         REG_MAX_ETA:    v = DATA_W'(grid.max_eta);
         REG_ETA_TOWERS: v = DATA_W'(grid.eta_count);
         REG_PHI_TOWERS: v = DATA_W'(grid.phi_count);
         REG_SHIFT_ETA:  v = DATA_W'(grid.shift_eta);
         REG_SHIFT_PHI:  v = DATA_W'(grid.shift_phi);
         default:        v = '0;
      endcase
      return v;
   endfunction

   function automatic int field_check(input string label, input logic [15:0] want,
                                      input logic [15:0] got);
      if (got !== want) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, label, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      tower_hit_type          want;
      tower_hit_type          got;
      logic [REG_IDX_W-1:0]   idx;
      int                     errs;
      errs = 0;
      if (reset) begin
         grid <= '{RESET_MAX_ETA, RESET_ETA_TOWERS, RESET_PHI_TOWERS, 1'b0, 1'b0};
         expected_towers.delete();
         fail_count <= 0;
         results_seen <= 0;
         pending <= 0;
      end else begin
         idx = paddr[REG_IDX_W+1:2];
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (idx)
                  REG_MAX_ETA:    grid.max_eta   <= pwdata[MAX_W-1:0];
                  REG_ETA_TOWERS: grid.eta_count <= pwdata[COUNT_W-1:0];
                  REG_PHI_TOWERS: grid.phi_count <= pwdata[COUNT_W-1:0];
                  REG_SHIFT_ETA:  grid.shift_eta <= pwdata[0];
                  REG_SHIFT_PHI:  grid.shift_phi <= pwdata[0];
                  default: ;
               endcase
            end else if (idx <= REG_SHIFT_PHI && prdata !== grid_reg_value(idx)) begin
               $display("%0t mismatch register %0d expected %0h actual %0h",
                        $time, idx, grid_reg_value(idx), prdata);
               errs++;
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            expected_towers.push_back(locate_tower(req_chan.eta_coord, req_chan.phi_angle,
                                                   grid));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen <= results_seen + 1;
            got = '{rsp_chan.tower_index, rsp_chan.eta_bin, rsp_chan.phi_bin,
                    rsp_chan.out_of_range};
            if (expected_towers.size() == 0) begin
               $display("%0t mismatch unexpected tower expected none actual %0d",
                        $time, got.tower_index);
               errs++;
            end else begin
               want = expected_towers.pop_front();
               errs += field_check("tower_index", 16'(want.tower_index), 16'(got.tower_index));
               errs += field_check("eta_bin", 16'(want.eta_bin), 16'(got.eta_bin));
               errs += field_check("phi_bin", 16'(want.phi_bin), 16'(got.phi_bin));
               errs += field_check("out_of_range", 16'(want.out_of_range),
                                   16'(got.out_of_range));
            end
         end
         fail_count <= fail_count + errs;
         pending <= expected_towers.size();
      end
   end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the periodic tower grid index block. Programs a
// series of grids over APB, from the reset grid through the extremes and
// degenerate counts to random ones, and streams coordinates aimed at the
// range limits and tower boundaries, with random request gaps, random output
// stalls and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
   import ptgi_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_OFF    = 300;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   ptgi_req_if req_chan();
   ptgi_rsp_if rsp_chan();

   int fail_count;
   int results_seen;
   int pending;
   int coords_sent;
   int cycle_count;
   bit quiet;
   bit hold_request;
   int grid_max;
   int grid_ne;
   int grid_np;
   bit grid_se;
   bit grid_sp;

   periodic_tower_grid_index u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   tower_grid_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .fail_count   (fail_count),
      .results_seen (results_seen),
      .pending      (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int hold;
      int r;
      hold = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold = HOLD_OFF;
         end
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            hold--;
         end else if (quiet) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               hold = $urandom_range(8, 40);
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= (r >= 28);
            end
         end
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [COORD_W-1:0] pick_eta();
      int r;
      int v;
      int k;
      r = $urandom_range(0, 99);
      if (r < 30 || grid_max == 0) begin
         v = int'($urandom_range(0, 65535)) - 32768;
      end else if (r < 55) begin
         v = grid_max + int'($urandom_range(0, 6)) - 3;
         if ($urandom_range(0, 1)) v = -v;
      end else if (r < 80) begin
         v = int'($urandom_range(0, 2 * grid_max - 2)) - (grid_max - 1);
      end else begin
         k = $urandom_range(0, grid_ne);
         v = (k * 2 * grid_max - (grid_se ? grid_max : 0)) / grid_ne - grid_max
             + int'($urandom_range(0, 2)) - 1;
      end
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[COORD_W-1:0];
   endfunction

   function automatic logic [COORD_W-1:0] pick_phi();
      int r;
      int v;
      int k;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         v = $urandom_range(0, 65535);
      end else if (r < 85) begin
         k = $urandom_range(0, grid_np);
         v = (k * 65536 - (grid_sp ? 32768 : 0)) / grid_np + int'($urandom_range(0, 2)) - 1;
      end else begin
         case ($urandom_range(0, 3))
            0:       v = 0;
            1:       v = 65535;
            2:       v = 32768;
            default: v = 32767;
         endcase
      end
      return v[COORD_W-1:0];
   endfunction

   task automatic apb_access(input bit is_write, input logic [REG_IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_grid(input int max_v, input int ne_v, input int np_v,
                             input bit se_v, input bit sp_v, input bit junk);
      logic [DATA_W-1:0] hi;
      hi = junk ? $urandom : '0;
      apb_access(1'b1, REG_MAX_ETA, (hi << MAX_W) | DATA_W'(max_v));
      apb_access(1'b1, REG_ETA_TOWERS, (hi << COUNT_W) | DATA_W'(ne_v));
      apb_access(1'b1, REG_PHI_TOWERS, (hi << COUNT_W) | DATA_W'(np_v));
      apb_access(1'b1, REG_SHIFT_ETA, (hi << 1) | DATA_W'(se_v));
      apb_access(1'b1, REG_SHIFT_PHI, (hi << 1) | DATA_W'(sp_v));
      if (junk) begin
         apb_access(1'b1, REG_IDX_W'(REG_SHIFT_PHI + 1 + $urandom_range(0, 2)), $urandom);
      end
      for (int i = REG_MAX_ETA; i <= REG_SHIFT_PHI; i++) begin
         apb_access(1'b0, REG_IDX_W'(i), '0);
      end
      grid_max = max_v % (1 << MAX_W);
      ne_v = ne_v % (1 << COUNT_W);
      np_v = np_v % (1 << COUNT_W);
      grid_ne = (ne_v == 0) ? 1 : ((ne_v > MAX_ETA_BINS) ? MAX_ETA_BINS : ne_v);
      grid_np = (np_v == 0) ? 1 : ((np_v > MAX_PHI_BINS) ? MAX_PHI_BINS : np_v);
      grid_se = se_v;
      grid_sp = sp_v;
   endtask

   task automatic send_coord(input logic [COORD_W-1:0] eta, input logic [COORD_W-1:0] phi);
      int gap;
      gap = quiet ? 0 : gap_len();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.eta_coord <= eta;
      req_chan.phi_angle <= phi;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      coords_sent++;
   endtask

   task automatic wait_drained();
      while (results_seen < coords_sent) @(posedge clock);
   endtask

   task automatic run_phase(input int count, input bit squeeze);
      for (int i = 0; i < count; i++) begin
         if (squeeze && i == 20) hold_request = 1'b1;
         send_coord(pick_eta(), pick_phi());
      end
      req_chan.valid <= 1'b0;
      wait_drained();
   endtask

   initial begin
      int r;
      int max_v;
      int ne_v;
      int np_v;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.eta_coord <= '0;
      req_chan.phi_angle <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      quiet = 1'b0;
      hold_request = 1'b0;
      coords_sent = 0;
      grid_max = RESET_MAX_ETA;
      grid_ne = RESET_ETA_TOWERS;
      grid_np = RESET_PHI_TOWERS;
      grid_se = 1'b0;
      grid_sp = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset grid: range limits, sign extremes, phi half turn
      send_coord(16'd0, 16'd0);
      send_coord(16'h8000, 16'hFFFF);
      send_coord(16'h7FFF, 16'd0);
      send_coord(16'd20479, 16'hFFFF);
      send_coord(16'(-20479), 16'd0);
      send_coord(16'd20480, 16'd1234);
      send_coord(16'(-20480), 16'd32768);
      send_coord(16'(-20481), 16'd5);
      send_coord(16'd20481, 16'd9);
      send_coord(16'd1, 16'd32767);
      send_coord(16'hFFFF, 16'd32768);
      send_coord(16'h5555, 16'hAAAA);
      send_coord(16'h2AAA, 16'h5555);
      run_phase(80, 1'b0);

      // widest grid with both half-tower shifts: wrap of the top towers
      apply_grid(32767, 64, 64, 1'b1, 1'b1, 1'b0);
      send_coord(16'd32766, 16'hFFFF);
      send_coord(16'(-32766), 16'd0);
      send_coord(16'h7FFF, 16'd1024);
      send_coord(16'(-32767), 16'd512);
      send_coord(16'h8000, 16'd511);
      send_coord(16'd0, 16'd65023);
      send_coord(16'd16383, 16'd65024);
      send_coord(16'(-16384), 16'd32767);
      run_phase(150, 1'b0);

      // single tower, smallest nonzero half-extent
      apply_grid(1, 1, 1, 1'b0, 1'b1, 1'b1);
      run_phase(100, 1'b0);

      // zero half-extent and zero tower counts
      apply_grid(0, 0, 0, 1'b1, 1'b0, 1'b0);
      run_phase(60, 1'b0);

      // counts above the limit saturate
      apply_grid(32767, 127, 100, 1'b0, 1'b0, 1'b1);
      quiet = 1'b1;
      run_phase(150, 1'b0);
      quiet = 1'b0;

      // back up the block with a long output hold-off
      apply_grid(20480, 65, 63, 1'b1, 1'b1, 1'b0);
      run_phase(150, 1'b1);

      for (int p = 0; p < 8; p++) begin
         r = $urandom_range(0, 99);
         if (r < 25) max_v = $urandom_range(1, 64);
         else if (r < 35) max_v = 32767;
         else if (r < 38) max_v = 0;
         else max_v = $urandom_range(1, 32767);
         r = $urandom_range(0, 99);
         if (r < 8) ne_v = 0;
         else if (r < 18) ne_v = $urandom_range(65, 127);
         else ne_v = $urandom_range(1, 64);
         r = $urandom_range(0, 99);
         if (r < 8) np_v = 0;
         else if (r < 18) np_v = $urandom_range(65, 127);
         else np_v = $urandom_range(1, 64);
         apply_grid(max_v, ne_v, np_v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
         quiet = (p % 3 == 2);
         run_phase(105, 1'b0);
      end
      quiet = 1'b0;

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[periodic_tower_grid_index.f]
sv/ptgi_pkg.sv
sv/ptgi_if.sv
sv/ptgi_front.sv
sv/ptgi_queue.sv
sv/ptgi_back.sv
sv/periodic_tower_grid_index.sv
test/tower_grid_checker.sv
test/tb.sv
